@@ src/sparse_bitmap_word_store_core_macros.svh @@
// Assertion macros for the sparse bitmap word store.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SPARSE_BITMAP_WORD_STORE_CORE_MACROS_SVH
`define SPARSE_BITMAP_WORD_STORE_CORE_MACROS_SVH

`ifndef SYNTH
`define SBWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBWS_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBWS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SBWS_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

@@ src/sbws_pkg.sv @@
// Shared types, command codes and bit-search functions for the sparse bitmap word store.
// No dependencies; used by sbws_summary and sparse_bitmap_word_store_core.
package sbws_pkg;

    localparam int ROW_MAX_W = 10;

    typedef enum logic [2:0] {
        CMD_RD_BIT  = 3'd0,
        CMD_WR_BIT  = 3'd1,
        CMD_RD_WORD = 3'd2,
        CMD_WR_WORD = 3'd3,
        CMD_FIND_GE = 3'd4,
        CMD_FIND_GT = 3'd5,
        CMD_FIND_LT = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EVAL2,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [9:0]  found_index;
        logic        found;
        logic [63:0] read_word;
        logic        read_bit;
    } t_res;

    typedef struct packed {
        logic                 cur_valid;
        logic                 up_hit;
        logic [ROW_MAX_W-1:0] up_row;
        logic                 dn_hit;
        logic [ROW_MAX_W-1:0] dn_row;
    } t_sum_q;

    function automatic logic [5:0] f_lowest(input logic [63:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 63; i >= 0; i--) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

    function automatic logic [5:0] f_highest(input logic [63:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

endpackage

@@ src/sbws_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sbws_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/sbws_summary.sv @@
// Row summary: one flag per 64-word row of the mark memory, set when a mark lands in it.
// Depends on sbws_pkg; answers nearest non-empty row above and below a query row.
module sbws_summary
    import sbws_pkg::*;
#(
    parameter int NROWS = 16,
    parameter int RW    = (NROWS > 1) ? $clog2(NROWS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_set,
    input  logic [RW-1:0] i_set_row,
    input  logic [16:0]   i_query_row,
    output t_sum_q        o_q
);

    logic [NROWS-1:0] r_valid;
    logic [NROWS-1:0] n_valid;

    always_comb begin
        n_valid = r_valid;
        if (i_set) n_valid[i_set_row] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_comb begin
        o_q           = '0;
        o_q.cur_valid = (i_query_row < 17'(NROWS)) && r_valid[i_query_row[RW-1:0]];
        for (int r = NROWS - 1; r >= 0; r--) begin
            if (r_valid[r] && (17'(r) > i_query_row)) begin
                o_q.up_hit = 1'b1;
                o_q.up_row = ROW_MAX_W'(r);
            end
        end
        for (int r = 0; r < NROWS; r++) begin
            if (r_valid[r] && (17'(r) < i_query_row)) begin
                o_q.dn_hit = 1'b1;
                o_q.dn_row = ROW_MAX_W'(r);
            end
        end
    end

endmodule

@@ src/sparse_bitmap_word_store_core.sv @@
// Sparse bitmap word store: a WORDS x 64 bit bitmap, one mark per word, one request in and
// one result out per request. The word memory and the mark row memory are read when a
// request is accepted; the request is then evaluated and written back. A find whose start
// row holds no candidate adds a second mark row read, its row picked from the row summary
// flags. The result sits in an output register, so the next request is taken while it
// waits. Reset clears the summary flags; words and mark rows behind a clear
// flag read as zero, so no clearing pass is needed.
// Depends on sbws_pkg, sbws_ram, sbws_summary and the macros header.
`include "sparse_bitmap_word_store_core_macros.svh"

module sparse_bitmap_word_store_core
    import sbws_pkg::*;
#(
    parameter int WORDS = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[2:0], bit_index[18:3], bit_value[19], word_index[29:20], word_data[93:30],
    // search_start[103:94]
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // read_bit[0], read_word[64:1], found[65], found_index[75:66], zero[79:76]
    output logic [79:0]  m_axis_tdata
);

    localparam int AW    = $clog2(WORDS);
    localparam int NROWS = (WORDS + 63) / 64;
    localparam int RW    = (NROWS > 1) ? $clog2(NROWS) : 1;

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic [10:0] r_idx;
    logic [5:0]  r_bpos;
    logic        r_bval;
    logic [63:0] r_wdata;
    logic [RW-1:0] r_row2, n_row2;
    t_res        r_res, n_res;
    t_res        r_out_data, n_out_data;
    logic        r_out_valid, n_out_valid;

    t_cmd        in_cmd;
    logic [10:0] rd_idx;
    logic [16:0] rd_row17;
    logic        accept;

    logic [16:0] idx17, row17;
    logic        word_ok;
    logic [5:0]  pos;
    logic [63:0] row_marks, word, bit_word, mask_up, mask_dn, wd_rdata, mk_rdata;
    logic [63:0] wd_wdata, mk_wdata;
    logic        wd_we, mk_we, need_second, done, out_free;
    logic [RW-1:0] mk_raddr;
    t_sum_q      sum_q;

    assign in_cmd        = t_cmd'(s_axis_tdata[2:0]);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        case (in_cmd)
            CMD_RD_BIT, CMD_WR_BIT:   rd_idx = {1'b0, s_axis_tdata[18:9]};
            CMD_RD_WORD, CMD_WR_WORD: rd_idx = {1'b0, s_axis_tdata[29:20]};
            CMD_FIND_GE, CMD_FIND_LT: rd_idx = {1'b0, s_axis_tdata[103:94]};
            CMD_FIND_GT:              rd_idx = {1'b0, s_axis_tdata[103:94]} + 11'd1;
            default:                  rd_idx = '0;
        endcase
    end

    assign rd_row17 = {6'd0, rd_idx} >> 6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= in_cmd;
            r_idx   <= rd_idx;
            r_bpos  <= s_axis_tdata[8:3];
            r_bval  <= s_axis_tdata[19];
            r_wdata <= s_axis_tdata[93:30];
        end
        r_row2     <= n_row2;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign idx17   = {6'd0, r_idx};
    assign row17   = idx17 >> 6;
    assign word_ok = idx17 < 17'(WORDS);
    assign pos     = r_idx[5:0];

    assign row_marks = mk_rdata & {64{sum_q.cur_valid}};
    assign word      = (row_marks[pos] && word_ok) ? wd_rdata : 64'd0;
    assign bit_word  = r_bval ? (word | (64'd1 << r_bpos)) : (word & ~(64'd1 << r_bpos));
    assign mask_up   = row_marks & (~64'd0 << pos);
    assign mask_dn   = row_marks & ~(~64'd0 << pos);
    assign out_free  = !r_out_valid || m_axis_tready;

    always_comb begin
        n_res       = '0;
        wd_we       = 1'b0;
        mk_we       = 1'b0;
        wd_wdata    = r_wdata;
        mk_wdata    = row_marks | (64'd1 << pos);
        need_second = 1'b0;
        n_row2      = r_row2;
        if (r_state == ST_EVAL) begin
            case (r_cmd)
                CMD_RD_BIT: n_res.read_bit = word[r_bpos];
                CMD_WR_BIT: begin
                    if (word_ok) begin
                        wd_we       = 1'b1;
                        mk_we       = 1'b1;
                        wd_wdata    = bit_word;
                        n_res.found = 1'b1;
                    end
                end
                CMD_RD_WORD: n_res.read_word = word;
                CMD_WR_WORD: begin
                    if (word_ok) begin
                        wd_we       = 1'b1;
                        mk_we       = 1'b1;
                        n_res.found = 1'b1;
                    end
                end
                CMD_FIND_GE, CMD_FIND_GT: begin
                    if (|mask_up) begin
                        n_res.found       = 1'b1;
                        n_res.found_index = 10'({row17, f_lowest(mask_up)});
                    end else if (sum_q.up_hit) begin
                        need_second = 1'b1;
                        n_row2      = sum_q.up_row[RW-1:0];
                    end
                end
                CMD_FIND_LT: begin
                    if (|mask_dn) begin
                        n_res.found       = 1'b1;
                        n_res.found_index = 10'({row17, f_highest(mask_dn)});
                    end else if (sum_q.dn_hit) begin
                        need_second = 1'b1;
                        n_row2      = sum_q.dn_row[RW-1:0];
                    end
                end
                default: n_res = '0;
            endcase
        end else if (r_state == ST_EVAL2) begin
            n_res.found = 1'b1;
            if (r_cmd == CMD_FIND_LT) begin
                n_res.found_index = 10'({r_row2, f_highest(mk_rdata)});
            end else begin
                n_res.found_index = 10'({r_row2, f_lowest(mk_rdata)});
            end
        end else if (r_state == ST_HOLD) begin
            n_res = r_res;
        end

        done = ((r_state == ST_EVAL) && !need_second) || (r_state == ST_EVAL2)
            || (r_state == ST_HOLD);
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        if (done && out_free) begin
            n_out_valid = 1'b1;
            n_out_data  = n_res;
        end

        mk_raddr = (r_state == ST_EVAL) ? n_row2 : rd_row17[RW-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept) n_state = ST_EVAL;
            ST_EVAL: begin
                if (need_second) n_state = ST_EVAL2;
                else if (out_free) n_state = ST_IDLE;
                else n_state = ST_HOLD;
            end
            ST_EVAL2: n_state = out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    sbws_ram #(
        .WIDTH (64),
        .DEPTH (WORDS)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (wd_we),
        .i_waddr (idx17[AW-1:0]),
        .i_wdata (wd_wdata),
        .i_raddr (AW'({6'd0, rd_idx})),
        .o_rdata (wd_rdata)
    );

    sbws_ram #(
        .WIDTH (64),
        .DEPTH (NROWS)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mk_we),
        .i_waddr (row17[RW-1:0]),
        .i_wdata (mk_wdata),
        .i_raddr (mk_raddr),
        .o_rdata (mk_rdata)
    );

    sbws_summary #(
        .NROWS (NROWS)
    ) u_summary (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_set       (mk_we),
        .i_set_row   (row17[RW-1:0]),
        .i_query_row (row17),
        .o_q         (sum_q)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_data};

    `SBWS_ASSERT(a_accept_to_eval, i_clk, i_rst_n, (accept |=> (r_state == ST_EVAL)), "request accepted but not evaluated")
    `SBWS_ASSERT(a_hold_busy, i_clk, i_rst_n, ((r_state == ST_HOLD) |-> r_out_valid), "holding a result while the output is free")
    `SBWS_ASSERT(a_write_in_eval, i_clk, i_rst_n, ((wd_we || mk_we) |-> ((r_state == ST_EVAL) && word_ok)), "memory write outside evaluation or out of range")
    `SBWS_ASSERT(a_second_after_find, i_clk, i_rst_n, ((r_state == ST_EVAL2) |-> (($past(r_state) == ST_EVAL) && ((r_cmd == CMD_FIND_GE) || (r_cmd == CMD_FIND_GT) || (r_cmd == CMD_FIND_LT)))), "second mark read without a find")

endmodule

@@ tb/sparse_bitmap_word_store_core_checker.sv @@
// Result checker for sparse_bitmap_word_store_core: tracks the bitmap words and written marks
// from accepted requests, predicts each result and compares it with the output stream.
// Depends on sbws_pkg for the command codes and the result layout.
module sparse_bitmap_word_store_core_checker
    import sbws_pkg::*;
#(
    parameter int WORDS = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [103:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [79:0]  i_m_tdata,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] word_mem [WORDS];
    bit          mark_bits [WORDS];
    t_res        awaited_results [$];
    int          fail_count = 0;

    function automatic logic [63:0] word_or_zero(input int w);
        return (w < WORDS && mark_bits[w]) ? word_mem[w] : 64'd0;
    endfunction

    function automatic logic put_word(input int w, input logic [63:0] d);
        if (w >= WORDS) return 1'b0;
        word_mem[w]  = d;
        mark_bits[w] = 1'b1;
        return 1'b1;
    endfunction

    function automatic t_res apply_request(input logic [103:0] req);
        t_cmd        cmd;
        logic [15:0] bit_idx;
        logic        bit_val;
        logic [63:0] word_dat;
        logic [63:0] v;
        int          word_idx;
        int          start;
        int          w;
        int          pos;
        t_res        res;
        cmd      = t_cmd'(req[2:0]);
        bit_idx  = req[18:3];
        bit_val  = req[19];
        word_idx = int'(req[29:20]);
        word_dat = req[93:30];
        start    = int'(req[103:94]);
        res      = '0;
        pos      = -1;
        w        = int'(bit_idx[15:6]);
        case (cmd)
            CMD_RD_BIT: begin
                v = word_or_zero(w);
                res.read_bit = v[bit_idx[5:0]];
            end
            CMD_WR_BIT: begin
                v = word_or_zero(w);
                v[bit_idx[5:0]] = bit_val;
                res.found = put_word(w, v);
            end
            CMD_RD_WORD: res.read_word = word_or_zero(word_idx);
            CMD_WR_WORD: res.found = put_word(word_idx, word_dat);
            CMD_FIND_GE, CMD_FIND_GT: begin
                for (int i = (cmd == CMD_FIND_GE) ? start : start + 1; i < WORDS; i++) begin
                    if (mark_bits[i] && pos < 0) pos = i;
                end
            end
            CMD_FIND_LT: begin
                for (int i = ((start < WORDS) ? start : WORDS) - 1; i >= 0; i--) begin
                    if (mark_bits[i] && pos < 0) pos = i;
                end
            end
            default: ;
        endcase
        if (pos >= 0) begin
            res.found       = 1'b1;
            res.found_index = 10'(pos);
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            foreach (mark_bits[i]) mark_bits[i] = 1'b0;
            awaited_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_res'(i_m_tdata[75:0]);
                if (awaited_results.size() == 0) begin
                    note_mismatch("unrequested result", 64'd0, 64'(i_m_tdata));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.read_bit !== want.read_bit)
                        note_mismatch("read_bit", 64'(want.read_bit), 64'(got.read_bit));
                    if (got.read_word !== want.read_word)
                        note_mismatch("read_word", want.read_word, got.read_word);
                    if (got.found !== want.found)
                        note_mismatch("found", 64'(want.found), 64'(got.found));
                    if (got.found_index !== want.found_index)
                        note_mismatch("found_index", 64'(want.found_index),
                                      64'(got.found_index));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_results.push_back(apply_request(i_s_tdata));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= awaited_results.size();
    end

endmodule

@@ tb/sparse_bitmap_word_store_core_tb.sv @@
// Top-level testbench for sparse_bitmap_word_store_core: drives directed and random requests
// with random gaps and output stalls, and gives the verdict from the checker's failure count.
// Depends on sbws_pkg, the core and sparse_bitmap_word_store_core_checker.
module sparse_bitmap_word_store_core_tb;
    import sbws_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WORDS        = 1024;
    localparam int          RANDOM_ITEMS = 1100;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam logic [2:0]  CMD_UNUSED   = 3'd7;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // cmd, bit_index, bit_value, word_index, word_data, search_start
    logic [103:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // read_bit, read_word, found, found_index, zero pad
    logic [79:0]  m_axis_tdata;
    int           fail_count;
    int           pending;

    bit           was_written [WORDS];
    int           written_list [$];
    int           item_no = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sparse_bitmap_word_store_core #(
        .WORDS(WORDS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    sparse_bitmap_word_store_core_checker #(
        .WORDS(WORDS)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic int idle_len(input int calm_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < calm_pct) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [103:0] make_req(input logic [2:0] cmd, input int bit_idx,
                                              input logic bit_val, input int word_idx,
                                              input logic [63:0] word_dat, input int start);
        return {10'(start), word_dat, 10'(word_idx), bit_val, 16'(bit_idx), cmd};
    endfunction

    task automatic send_req(input logic [103:0] req);
        int idle;
        idle = idle_len(((item_no / 64) % 3 == 0) ? 100 : 55);
        if (idle > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (idle - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        item_no++;
    endtask

    task automatic write_word(input int w, input logic [63:0] d);
        if (!was_written[w]) begin
            was_written[w] = 1'b1;
            written_list.push_back(w);
        end
        send_req(make_req(CMD_WR_WORD, $urandom_range(0, 65535), 1'($urandom), w, d,
                          $urandom_range(0, 1023)));
    endtask

    // bit and word reads, and bit writes, only touch words written since reset
    function automatic int pick_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    task automatic send_bit_op(input logic [2:0] cmd, input int bit_idx, input logic bit_val);
        send_req(make_req(cmd, bit_idx, bit_val, $urandom_range(0, 1023), rand_word(),
                          $urandom_range(0, 1023)));
    endtask

    task automatic send_find(input logic [2:0] cmd, input int start);
        send_req(make_req(cmd, $urandom_range(0, 65535), 1'($urandom),
                          $urandom_range(0, 1023), rand_word(), start));
    endtask

    task automatic send_word_read(input int w);
        send_req(make_req(CMD_RD_WORD, $urandom_range(0, 65535), 1'($urandom), w,
                          rand_word(), $urandom_range(0, 1023)));
    endtask

    initial begin : sink
        int hold;
        int ticks;
        hold  = 0;
        ticks = 0;
        forever begin
            @(negedge i_clk);
            ticks++;
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= 1'b1;
                hold = idle_len(((ticks / 300) % 3 == 0) ? 100 : 60);
            end
        end
    end

    initial begin : watchdog
        int n;
        for (n = 0; n < CYCLE_LIMIT; n++) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int counted;
        int sel;
        int w;
        int start;
        int cluster;
        int r;
        logic [63:0] d;
        logic [2:0] find_cmd;
        int edges [6];

        edges = '{0, 1, 63, 64, 1022, 1023};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty bitmap, unused command, edge words
        send_find(CMD_FIND_GE, 0);
        send_find(CMD_FIND_GT, 0);
        send_find(CMD_FIND_LT, 1023);
        send_req(make_req(CMD_UNUSED, 65535, 1'b1, 1023, '1, 1023));
        write_word(0, '1);
        write_word(1023, 64'd0);
        write_word(64, 64'ha5a5_a5a5_a5a5_a5a5);
        write_word(63, 64'h5a5a_5a5a_5a5a_5a5a);
        send_word_read(0);
        send_word_read(1023);
        send_word_read(64);
        send_bit_op(CMD_WR_BIT, 65535, 1'b1);
        send_bit_op(CMD_WR_BIT, 0, 1'b0);
        send_bit_op(CMD_WR_BIT, 4101, 1'b1);
        send_bit_op(CMD_RD_BIT, 65535, 1'b0);
        send_bit_op(CMD_RD_BIT, 0, 1'b1);
        send_bit_op(CMD_RD_BIT, 4101, 1'b0);
        send_find(CMD_FIND_GE, 0);
        send_find(CMD_FIND_GT, 0);
        send_find(CMD_FIND_LT, 0);
        send_find(CMD_FIND_LT, 1023);
        send_find(CMD_FIND_GE, 1023);
        send_find(CMD_FIND_GT, 1023);
        send_find(CMD_FIND_GE, 65);
        send_find(CMD_FIND_GT, 64);
        send_req(make_req(CMD_UNUSED, 0, 1'b0, 0, 64'd0, 0));

        counted = 0;
        cluster = $urandom_range(0, 1023);
        while (counted < RANDOM_ITEMS) begin
            if (counted % 100 == 0) cluster = $urandom_range(0, 1023);
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                send_req(make_req(CMD_UNUSED, $urandom_range(0, 65535), 1'($urandom),
                                  $urandom_range(0, 1023), rand_word(),
                                  $urandom_range(0, 1023)));
                continue;
            end
            if (sel < 16) begin
                r = $urandom_range(0, 99);
                if (r < 50) w = (cluster + $urandom_range(0, 15)) % WORDS;
                else if (r < 60) w = edges[$urandom_range(0, 5)];
                else w = $urandom_range(0, 1023);
                r = $urandom_range(0, 7);
                d = (r == 0) ? '1 : (r == 1) ? 64'd0 : rand_word();
                write_word(w, d);
            end else if (sel < 30) begin
                send_bit_op(CMD_WR_BIT, pick_written() * 64 + $urandom_range(0, 63),
                            1'($urandom));
            end else if (sel < 45) begin
                send_bit_op(CMD_RD_BIT, pick_written() * 64 + $urandom_range(0, 63),
                            1'($urandom));
            end else if (sel < 58) begin
                send_word_read(pick_written());
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    start = edges[$urandom_range(0, 5)];
                end else if (r < 50) begin
                    start = pick_written() + $urandom_range(0, 6) - 3;
                    if (start < 0) start = 0;
                    if (start > 1023) start = 1023;
                end else begin
                    start = $urandom_range(0, 1023);
                end
                r = $urandom_range(0, 2);
                find_cmd = (r == 0) ? CMD_FIND_GE : (r == 1) ? CMD_FIND_GT : CMD_FIND_LT;
                send_find(find_cmd, start);
            end
            counted++;
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/sbws_pkg.sv
src/sbws_ram.sv
src/sbws_summary.sv
src/sparse_bitmap_word_store_core.sv
tb/sparse_bitmap_word_store_core_checker.sv
tb/sparse_bitmap_word_store_core_tb.sv
